[hw/rtl/pwl_pkg.sv]
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared constants, command codes and controller/datapath bundles for the
// piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package pwl_pkg;

  // table geometry
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Q16.16 data path widths
  localparam int DATA_W    = 32;
  localparam int TOL_W     = 31;
  localparam int MAG_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * DATA_W + 1;
  localparam int QUO_W     = DATA_W + 2;
  localparam int SUM_W     = QUO_W + 2;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIVC_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic dispatch;
    logic scan;
    logic fetch;
    logic load_best;
    logic load_nb;
    logic mul;
    logic div;
    logic sum;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_scan;
    logic scan_done;
    logic stop_best;
    logic same_x;
    logic div_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

[hw/rtl/pwl_ctrl.sv]
// ----------------------------------------------------------------------------
// pwl_ctrl
// Sequencing state machine: dispatch, nearest-point scan, neighbour fetch,
// multiply, serial divide, saturating sum and result hand-off.
// ----------------------------------------------------------------------------
module pwl_ctrl import pwl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_SCAN     = 10'b00_0000_0100,
    S_FETCH    = 10'b00_0000_1000,
    S_BEST     = 10'b00_0001_0000,
    S_NB       = 10'b00_0010_0000,
    S_MUL      = 10'b00_0100_0000,
    S_DIV      = 10'b00_1000_0000,
    S_SUM      = 10'b01_0000_0000,
    S_EMIT     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        state_d = stat_i.go_scan ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = S_BEST;
      end
      S_BEST: begin
        cmd_o.load_best = 1'b1;
        state_d = stat_i.stop_best ? S_EMIT : S_NB;
      end
      S_NB: begin
        cmd_o.load_nb = 1'b1;
        state_d = stat_i.same_x ? S_EMIT : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (stat_i.div_last) state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/pwl_datapath.sv]
// ----------------------------------------------------------------------------
// pwl_datapath
// Point memory, point count, nearest-point search, interpolation arithmetic
// and the output register.
// ----------------------------------------------------------------------------
module pwl_datapath import pwl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_stat_t        stat_o,
  input  logic [1:0]        cmd_in_i,
  input  logic [DATA_W-1:0] x_value_i,
  input  logic [DATA_W-1:0] y_value_i,
  input  logic              cfg_valid_i,
  input  logic [TOL_W-1:0]  snap_tolerance_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] y_result_o,
  output logic [IDX_W-1:0]  nearest_index_o,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  point_count_o
);

  function automatic logic [MAG_W-1:0] mag(input logic [MAG_W-1:0] v);
    mag = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
  endfunction

  // configuration and table state
  logic [TOL_W-1:0] tol_q;
  logic [CNT_W-1:0] count_q;
  logic             full;

  // latched request
  cmd_e                     cmd_q;
  logic signed [DATA_W-1:0] qx_q;
  logic        [DATA_W-1:0] qy_q;

  // point memory, words are {x, y}
  logic [2*DATA_W-1:0] mem [MAX_POINTS];
  logic [2*DATA_W-1:0] rd_q;
  logic [IDX_W-1:0]    raddr;
  logic                mem_we;

  // scan
  logic [CNT_W-1:0] scan_q;
  logic             rdv_q;
  logic [IDX_W-1:0] tag_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [MAG_W-1:0] best_d_q;
  logic [MAG_W-1:0] pt_dist;

  // best point and neighbour
  logic signed [DATA_W-1:0] rx, ry;
  logic        [DATA_W-1:0] bx_q, by_q;
  logic                     side_q;
  logic                     side_up, has_nb, snap;
  logic [IDX_W-1:0]         nb_addr;

  // interpolation
  logic signed [DATA_W-1:0] x0, y0, x1, y1;
  logic        [MAG_W-1:0]  dy, dq, dx;
  logic        [MAG_W-1:0]  mdy_q, mdq_q, mdx_q;
  logic                     neg_q;
  logic signed [DATA_W-1:0] y0_q;
  logic [PROD_W-1:0]        prod_full;
  logic [PROD_W-1:0]        prod_q;
  logic [MAG_W-1:0]         rem_q;
  logic [MAG_W:0]           rem_sh;
  logic                     rem_ge;
  logic [QUO_W-1:0]         quo_q;
  logic                     big_q;
  logic [DIVC_W-1:0]        divc_q;
  logic signed [SUM_W-1:0]  y0_ext, quo_ext, sum_s;
  logic [SUM_W-DATA_W:0]    sum_top;
  logic [DATA_W-1:0]        sat_y;

  // result staging and output register
  logic [DATA_W-1:0] res_y_q;
  status_e           res_st_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_y_q;
  logic [IDX_W-1:0]  out_idx_q;
  status_e           out_st_q;
  logic [CNT_W-1:0]  out_cnt_q;

  assign full = (count_q == CNT_W'(MAX_POINTS));

  // ---- combinational helpers ----
  assign rx = $signed(rd_q[2*DATA_W-1:DATA_W]);
  assign ry = $signed(rd_q[DATA_W-1:0]);

  assign pt_dist = mag(MAG_W'(qx_q) - MAG_W'(rx));
  assign snap    = best_d_q < MAG_W'(tol_q);
  assign side_up = rx < qx_q;
  assign has_nb  = side_up ? ((CNT_W'(best_idx_q) + CNT_W'(1)) < count_q)
                           : (best_idx_q != '0);
  assign nb_addr = side_up ? best_idx_q + IDX_W'(1) : best_idx_q - IDX_W'(1);

  always_comb begin
    if (side_q) begin
      x0 = $signed(bx_q);
      y0 = $signed(by_q);
      x1 = rx;
      y1 = ry;
    end else begin
      x0 = rx;
      y0 = ry;
      x1 = $signed(bx_q);
      y1 = $signed(by_q);
    end
  end

  assign dy = MAG_W'(y1) - MAG_W'(y0);
  assign dq = MAG_W'(qx_q) - MAG_W'(x0);
  assign dx = MAG_W'(x1) - MAG_W'(x0);

  assign prod_full = PROD_W'(mdy_q) * PROD_W'(mdq_q);

  assign rem_sh = {rem_q, prod_q[PROD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, mdx_q};

  assign y0_ext  = SUM_W'(y0_q);
  assign quo_ext = $signed({2'b00, quo_q});
  assign sum_s   = neg_q ? (y0_ext - quo_ext) : (y0_ext + quo_ext);
  assign sum_top = sum_s[SUM_W-1:DATA_W-1];

  always_comb begin
    if (big_q) begin
      sat_y = neg_q ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else if ((sum_top == '0) || (sum_top == '1)) begin
      sat_y = sum_s[DATA_W-1:0];
    end else begin
      sat_y = sum_s[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                             : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (cmd_i.fetch) begin
      raddr = best_idx_q;
    end else if (cmd_i.load_best) begin
      raddr = nb_addr;
    end else begin
      raddr = scan_q[IDX_W-1:0];
    end
  end

  assign mem_we = cmd_i.dispatch && (cmd_q == CMD_APPEND) && !full;

  // ---- memory ----
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[count_q[IDX_W-1:0]] <= {qx_q, qy_q};
    rd_q <= mem[raddr];
  end

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= '0;
      count_q     <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) tol_q <= snap_tolerance_i;
      if (cmd_i.dispatch) begin
        if (cmd_q == CMD_CLEAR) begin
          count_q <= '0;
        end else if (mem_we) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      rdv_q <= cmd_i.scan && (scan_q < count_q);
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= cmd_e'(cmd_in_i);
      qx_q  <= $signed(x_value_i);
      qy_q  <= y_value_i;
    end

    if (cmd_i.dispatch) begin
      res_y_q    <= '0;
      best_idx_q <= '0;
      scan_q     <= '0;
      if ((cmd_q == CMD_APPEND) && full) begin
        res_st_q <= ST_FULL;
      end else if ((cmd_q == CMD_QUERY) && (count_q == '0)) begin
        res_st_q <= ST_EMPTY;
      end else begin
        res_st_q <= ST_OK;
      end
    end

    // issue one read per cycle, compare the registered word of the previous read
    if (cmd_i.scan) begin
      if (scan_q < count_q) scan_q <= scan_q + CNT_W'(1);
      tag_q <= scan_q[IDX_W-1:0];
      if (rdv_q && ((tag_q == '0) || (pt_dist < best_d_q))) begin
        best_d_q   <= pt_dist;
        best_idx_q <= tag_q;
      end
    end

    if (cmd_i.load_best) begin
      bx_q    <= rx;
      by_q    <= ry;
      res_y_q <= ry;
      side_q  <= side_up;
    end

    if (cmd_i.load_nb) begin
      mdy_q <= mag(dy);
      mdq_q <= mag(dq);
      mdx_q <= mag(dx);
      neg_q <= dy[MAG_W-1] ^ dq[MAG_W-1] ^ dx[MAG_W-1];
      y0_q  <= y0;
    end

    if (cmd_i.mul) begin
      prod_q <= prod_full;
      rem_q  <= '0;
      quo_q  <= '0;
      big_q  <= 1'b0;
      divc_q <= DIVC_W'(DIV_STEPS);
    end

    if (cmd_i.div) begin
      rem_q  <= rem_ge ? MAG_W'(rem_sh - {1'b0, mdx_q}) : rem_sh[MAG_W-1:0];
      quo_q  <= {quo_q[QUO_W-2:0], rem_ge};
      big_q  <= big_q | quo_q[QUO_W-1];
      prod_q <= {prod_q[PROD_W-2:0], 1'b0};
      divc_q <= divc_q - DIVC_W'(1);
    end

    if (cmd_i.sum) res_y_q <= sat_y;

    if (cmd_i.emit) begin
      out_y_q   <= res_y_q;
      out_idx_q <= best_idx_q;
      out_st_q  <= res_st_q;
      out_cnt_q <= count_q;
    end
  end

  assign stat_o.go_scan   = (cmd_q == CMD_QUERY) && (count_q != '0);
  assign stat_o.scan_done = (scan_q == count_q) && !rdv_q;
  assign stat_o.stop_best = snap || !has_nb;
  assign stat_o.same_x    = (rx == $signed(bx_q));
  assign stat_o.div_last  = (divc_q == DIVC_W'(1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign y_result_o      = out_y_q;
  assign nearest_index_o = out_idx_q;
  assign status_o        = out_st_q;
  assign point_count_o   = out_cnt_q;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table depth");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div |-> (rem_q < mdx_q))
    else $error("divider remainder not below divisor");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (res_st_q == ST_EMPTY)) |-> (count_q == '0))
    else $error("empty status with stored points");

  a_best_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (cmd_q == CMD_QUERY) && (res_st_q == ST_OK))
      |-> (CNT_W'(best_idx_q) < count_q))
    else $error("nearest index outside stored points");

endmodule

[hw/rtl/pwl_table_interpolator.sv]
// ----------------------------------------------------------------------------
// pwl_table_interpolator
// Piecewise-linear lookup over a table of Q16.16 (x, y) points appended in
// ascending x, with clear, append and interpolating query requests.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i / in_ready_o   cmd_i, x_value_i, y_value_i
//  out       source     out_valid_o / out_ready_i y_result_o, nearest_index_o,
//                                                 status_o, point_count_o
//  cfg       sink       cfg_valid_i / cfg_ready_o snap_tolerance_i
//
//  clear, append and no-op requests go from dispatch straight to the result
//  hand-off; a query on a non-empty table scans the point memory one word per
//  cycle, then fetches the nearest point and its neighbour; interpolation adds
//  the multiply and the 65-step restoring divider
//  one request is in flight at a time; the next is taken while the previous
//  result still sits in the output register
//  reset (rst_ni low, asynchronous) empties the table and zeroes the
//  tolerance; the point memory itself is not cleared
//  a stalled output holds the machine in its final state until taken
//
module pwl_table_interpolator import pwl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [DATA_W-1:0] x_value_i,
  input  logic [DATA_W-1:0] y_value_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] y_result_o,
  output logic [IDX_W-1:0]  nearest_index_o,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  point_count_o,
  // configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TOL_W-1:0]  snap_tolerance_i
);

  ctrl_cmd_t  ctrl_cmd;
  ctrl_stat_t ctrl_stat;

  // tolerance register accepts a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencing: dispatch, scan, neighbour fetch, multiply, divide, sum, emit
  pwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (ctrl_stat),
    .cmd_o      (ctrl_cmd)
  );

  // point memory, search and arithmetic, output register
  pwl_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .stat_o           (ctrl_stat),
    .cmd_in_i         (cmd_i),
    .x_value_i        (x_value_i),
    .y_value_i        (y_value_i),
    .cfg_valid_i      (cfg_valid_i),
    .snap_tolerance_i (snap_tolerance_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .y_result_o       (y_result_o),
    .nearest_index_o  (nearest_index_o),
    .status_o         (status_o),
    .point_count_o    (point_count_o)
  );

endmodule
